/* src/mfhd_pkg.sv */
// ----------------------------------------------------------------------------
// mfhd_pkg
// Types and constants shared by the MQTT fixed-header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mfhd_pkg;

    localparam int unsigned LEN_W         = 28;
    localparam int unsigned CFG_W         = 29;
    localparam int unsigned SEEN_W        = 3;
    localparam int unsigned MAX_HDR_BYTES = 5;

    localparam logic [7:0]  MORE_BIT      = 8'h80;
    localparam logic [6:0]  DIGIT_MASK    = 7'h7f;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    localparam logic [SEEN_W-1:0] LAST_LEN_IDX = SEEN_W'(MAX_HDR_BYTES - 1);

    typedef enum logic [2:0] {
        ST_HEADER    = 3'd0,
        ST_PAYLOAD   = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_DROPPED   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        PH_TYPE    = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DROP    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_connection;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [3:0]       packet_type;
        logic [3:0]       packet_flags;
        logic [LEN_W-1:0] decoded_length;
        logic             first_of_packet;
        logic             last_of_packet;
        logic [2:0]       status;
    } t_out_item;

    typedef struct packed {
        t_phase            phase;
        logic [SEEN_W-1:0] length_bytes_seen;
        logic [LEN_W-1:0]  length_accum;
        logic [LEN_W-1:0]  payload_left;
        logic [7:0]        type_and_flags;
    } t_state;

endpackage

`default_nettype wire

/* src/mfhd_framer.sv */
// ----------------------------------------------------------------------------
// mfhd_framer
// Next-state and result logic for one stream byte of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module mfhd_framer (
    input  mfhd_pkg::t_state                   i_state,
    input  mfhd_pkg::t_in_item                 i_item,
    input  logic [mfhd_pkg::CFG_W-1:0]         i_max_size,
    output mfhd_pkg::t_state                   o_state,
    output mfhd_pkg::t_out_item                o_result
);
    import mfhd_pkg::*;

    t_phase            cur_phase;
    logic [SEEN_W-1:0] seen_inc;
    logic [LEN_W-1:0]  digit;
    logic [LEN_W-1:0]  accum_sum;
    logic [CFG_W-1:0]  total;
    logic [LEN_W-1:0]  left_dec;
    logic              show;
    t_status           status;
    logic              first;
    logic              last;

    always_comb begin
        cur_phase = i_item.new_connection ? PH_TYPE : i_state.phase;
        seen_inc  = i_state.length_bytes_seen + SEEN_W'(1);
        digit     = LEN_W'({1'b0, i_item.rx_byte[6:0] & DIGIT_MASK})
                    << (7 * i_state.length_bytes_seen[1:0]);
        accum_sum = i_state.length_accum + digit;
        total     = CFG_W'(1) + CFG_W'(seen_inc) + CFG_W'(accum_sum);
        left_dec  = (i_state.payload_left != '0) ?
                    i_state.payload_left - LEN_W'(1) : i_state.payload_left;

        o_state = i_state;
        show    = 1'b1;
        status  = ST_HEADER;
        first   = 1'b0;
        last    = 1'b0;

        unique case (cur_phase)
            PH_TYPE: begin
                o_state.type_and_flags    = i_item.rx_byte;
                o_state.length_bytes_seen = '0;
                o_state.length_accum      = '0;
                o_state.payload_left      = '0;
                o_state.phase             = PH_LEN;
                first                     = 1'b1;
            end
            PH_LEN: begin
                o_state.length_accum      = accum_sum;
                o_state.length_bytes_seen = seen_inc;
                if ((i_item.rx_byte & MORE_BIT) != '0) begin
                    if (seen_inc >= LAST_LEN_IDX) begin
                        status        = ST_MALFORMED;
                        o_state.phase = PH_DROP;
                    end
                end else if (total > i_max_size) begin
                    status        = ST_TOO_LARGE;
                    o_state.phase = PH_DROP;
                end else if (accum_sum == '0) begin
                    last          = 1'b1;
                    o_state.phase = PH_TYPE;
                end else begin
                    o_state.payload_left = accum_sum;
                    o_state.phase        = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                status               = ST_PAYLOAD;
                o_state.payload_left = left_dec;
                if (left_dec == '0) begin
                    last          = 1'b1;
                    o_state.phase = PH_TYPE;
                end
            end
            PH_DROP: begin
                status = ST_DROPPED;
                show   = 1'b0;
            end
            default: begin
                status = ST_DROPPED;
                show   = 1'b0;
            end
        endcase

        o_result.data_byte       = i_item.rx_byte;
        o_result.packet_type     = show ? o_state.type_and_flags[7:4] : '0;
        o_result.packet_flags    = show ? o_state.type_and_flags[3:0] : '0;
        o_result.decoded_length  = show ? o_state.length_accum : '0;
        o_result.first_of_packet = first;
        o_result.last_of_packet  = last;
        o_result.status          = status;
    end

endmodule

`default_nettype wire

/* src/mqtt_fixed_header_deframer.sv */
// ----------------------------------------------------------------------------
// mqtt_fixed_header_deframer
// Frames MQTT control packets from a byte stream, one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in) carries one stream byte and a
//   new_connection flag per transaction. Output channel
//   (o_out_valid/i_out_ready/o_out) returns one result per input byte:
//   the byte, type and flags, decoded length, packet start/end marks and a
//   status code. Configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_data)
//   writes the maximum packet size; write it only while idle.
//   A result is registered, appearing the cycle after its byte is accepted.
//   Throughput: one byte per cycle with i_out_ready high, set by the single
//   output register; framing state updates in the cycle the byte is taken.
//   Reset: framing waits for a type byte, max size returns to 1024, and the
//   output register empties.
//   Stall: while a result waits and i_out_ready is low, o_in_ready drops and
//   the result holds; a byte is taken in the same cycle the result leaves.
//   After a malformed or oversized header, bytes are dropped until a byte
//   arrives with new_connection set.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_fixed_header_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mfhd_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mfhd_pkg::t_out_item         o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mfhd_pkg::CFG_W-1:0]  i_cfg_data
);
    import mfhd_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             r_out_valid;
    logic [CFG_W-1:0] r_max_size;
    logic             in_take;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    mfhd_framer u_framer (
        .i_state    (r_state),
        .i_item     (i_in),
        .i_max_size (r_max_size),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase             <= PH_TYPE;
            r_state.length_bytes_seen <= '0;
            r_state.length_accum      <= '0;
            r_state.payload_left      <= '0;
            r_state.type_and_flags    <= '0;
            r_out_valid               <= 1'b0;
            r_max_size                <= CFG_RESET;
        end else begin
            if (in_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* src/mfhd_checker.sv */
// ----------------------------------------------------------------------------
// mfhd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfhd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mfhd_pkg::t_out_item o_out
);
    import mfhd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted byte produced no result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("byte accepted while result stalled");

    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_DROPPED |->
            o_out.packet_type == '0 && o_out.decoded_length == '0 &&
            !o_out.first_of_packet && !o_out.last_of_packet)
        else $error("dropped byte carries packet fields");

endmodule

bind mqtt_fixed_header_deframer mfhd_checker u_mfhd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
